// File: rtl/gf2rr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf2rr_pkg
// Shared widths and register indexes for the GF(2) row reduction block.
// ----------------------------------------------------------------------------
package gf2rr_pkg;

    localparam int ROW_BITS_W = 16;
    localparam int OP_W       = 16;
    localparam int ROWNUM_W   = 4;
    localparam int RANK_W     = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RESET = 5'd16;
    localparam logic [CFG_DATA_W-1:0] COL_COUNT_RESET = 5'd16;

endpackage
`default_nettype wire

// File: rtl/gf2rr_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf2rr stream interfaces
// Valid/ready channels for matrix rows in and reduced rows out.
// ----------------------------------------------------------------------------
interface gf2rr_in_if;
    import gf2rr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface gf2rr_out_if;
    import gf2rr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROW_BITS_W-1:0] reduced_row;
    logic [OP_W-1:0]       operation_row;
    logic [ROWNUM_W-1:0]   row_number;
    logic [RANK_W-1:0]     rank_value;
    logic                  last_result;

    modport source (output valid, output reduced_row, output operation_row,
                    output row_number, output rank_value, output last_result,
                    input ready);
    modport sink   (input valid, input reduced_row, input operation_row,
                    input row_number, input rank_value, input last_result,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/gf2rr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf2rr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gf2rr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/gf2_row_reduce_with_inverse_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_row_reduce_with_inverse_top
// Gauss-Jordan elimination over GF(2) with accumulated row-operation matrix.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while the block is loading; a row with last_row
// set, or the row that reaches row_count, closes the matrix. Matrix and
// operation rows share one RAM with a single read port, and every elimination
// step goes row by row through it: a column with no pivot is a scan of the
// rows from the current rank down, and a column with a pivot adds a fetch of
// the rank row, then one read-modify-write pass over all m loaded rows.
// Columns stop at col_count or at full rank. Each result word is then read
// out of the RAM into the output register. Input ready is high only while
// loading; the last result word may still wait in the output register while
// the next matrix loads.
// ----------------------------------------------------------------------------
module gf2_row_reduce_with_inverse_top #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [gf2rr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gf2rr_pkg::CFG_DATA_W-1:0]  cfg_data,
    gf2rr_in_if.sink                               in_ch,
    gf2rr_out_if.source                            out_ch
);
    import gf2rr_pkg::*;

    localparam int ROW_W  = (MAX_COLS < ROW_BITS_W) ? MAX_COLS : ROW_BITS_W;
    localparam int DATA_W = ROW_W + OP_W;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = $clog2(ROW_W + 1);
    localparam int BIT_W  = (ROW_W > 1) ? $clog2(ROW_W) : 1;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_COL  = 7'b0000010,
        S_SRCH = 7'b0000100,
        S_GETR = 7'b0001000,
        S_PASS = 7'b0010000,
        S_ERD  = 7'b0100000,
        S_EGET = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_DATA_W-1:0] row_cnt_reg, col_cnt_reg;
    logic [CNT_W-1:0]      load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]      m_reg, m_next;
    logic [CNT_W-1:0]      rank_reg, rank_next;
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]      pidx_reg, pidx_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [DATA_W-1:0]     piv_reg, piv_next;
    logic [DATA_W-1:0]     rrow_reg, rrow_next;

    logic                  out_valid_reg;
    logic [ROW_BITS_W-1:0] out_row_reg;
    logic [OP_W-1:0]       out_op_reg;
    logic [ROWNUM_W-1:0]   out_num_reg;
    logic [RANK_W-1:0]     out_rank_reg;
    logic                  out_last_reg;

    logic [CNT_W-1:0]      rows_eff;
    logic [COL_W-1:0]      cols_eff;
    logic [ROW_W-1:0]      col_mask;
    logic [OP_W-1:0]       id_bit;
    logic [CNT_W-1:0]      load_inc;
    logic [CNT_W-1:0]      cur_inc;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0]     ram_wdata, ram_rdata;
    logic [ROW_W-1:0]      rd_mat;
    logic [OP_W-1:0]       rd_op;
    logic                  rd_hit;
    logic [DATA_W-1:0]     pass_base;
    logic [DATA_W-1:0]     pass_val;

    gf2rr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= ROW_COUNT_RESET;
            col_cnt_reg <= COL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_COUNT: row_cnt_reg <= cfg_data;
                CFG_COL_COUNT: col_cnt_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // clamped counts and column mask
    always_comb
    begin
        if (row_cnt_reg == '0)
            rows_eff = CNT_W'(1);
        else if (int'(row_cnt_reg) > MAX_ROWS)
            rows_eff = CNT_W'(MAX_ROWS);
        else
            rows_eff = CNT_W'(row_cnt_reg);

        if (col_cnt_reg == '0)
            cols_eff = COL_W'(1);
        else if (int'(col_cnt_reg) > ROW_W)
            cols_eff = COL_W'(ROW_W);
        else
            cols_eff = COL_W'(col_cnt_reg);
    end

    always_comb
    begin
        for (int k = 0; k < ROW_W; k++)
        begin
            col_mask[k] = (k < int'(cols_eff));
        end
    end

    assign id_bit   = OP_W'(1) << load_cnt_reg;
    assign load_inc = load_cnt_reg + 1'b1;
    assign cur_inc  = cur_reg + 1'b1;

    assign rd_mat = ram_rdata[ROW_W-1:0];
    assign rd_op  = ram_rdata[DATA_W-1:ROW_W];
    assign rd_hit = rd_mat[col_reg[BIT_W-1:0]];

    // swap and clear folded into one pass
    always_comb
    begin
        if (cur_reg == rank_reg)
            pass_base = piv_reg;
        else if (cur_reg == pidx_reg)
            pass_base = rrow_reg;
        else
            pass_base = ram_rdata;

        if ((cur_reg != rank_reg) && pass_base[col_reg[BIT_W-1:0]])
            pass_val = pass_base ^ piv_reg;
        else
            pass_val = pass_base;
    end

    assign in_ch.ready = (state_reg == S_LOAD);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        m_next        = m_reg;
        rank_next     = rank_reg;
        cur_next      = cur_reg;
        pidx_next     = pidx_reg;
        col_next      = col_reg;
        piv_next      = piv_reg;
        rrow_next     = rrow_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_ch.valid)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = load_cnt_reg[ADDR_W-1:0];
                    ram_wdata = {id_bit, in_ch.row_bits[ROW_W-1:0] & col_mask};
                    if (in_ch.last_row || (load_inc >= rows_eff))
                    begin
                        m_next        = load_inc;
                        load_cnt_next = '0;
                        col_next      = '0;
                        rank_next     = '0;
                        state_next    = S_COL;
                    end
                    else
                    begin
                        load_cnt_next = load_inc;
                    end
                end
            end
            S_COL:
            begin
                if ((col_reg == cols_eff) || (rank_reg == m_reg))
                begin
                    cur_next   = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    ram_raddr  = rank_reg[ADDR_W-1:0];
                    cur_next   = rank_reg;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (rd_hit)
                begin
                    piv_next   = ram_rdata;
                    pidx_next  = cur_reg;
                    ram_raddr  = rank_reg[ADDR_W-1:0];
                    state_next = S_GETR;
                end
                else if (cur_inc == m_reg)
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_COL;
                end
                else
                begin
                    ram_raddr = cur_inc[ADDR_W-1:0];
                    cur_next  = cur_inc;
                end
            end
            S_GETR:
            begin
                rrow_next  = ram_rdata;
                ram_raddr  = '0;
                cur_next   = '0;
                state_next = S_PASS;
            end
            S_PASS:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[ADDR_W-1:0];
                ram_wdata = pass_val;
                if (cur_inc == m_reg)
                begin
                    rank_next  = rank_reg + 1'b1;
                    col_next   = col_reg + 1'b1;
                    state_next = S_COL;
                end
                else
                begin
                    ram_raddr = cur_inc[ADDR_W-1:0];
                    cur_next  = cur_inc;
                end
            end
            S_ERD:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    ram_raddr  = cur_reg[ADDR_W-1:0];
                    state_next = S_EGET;
                end
            end
            S_EGET:
            begin
                if (cur_inc == m_reg)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cur_next   = cur_inc;
                    state_next = S_ERD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            m_reg        <= '0;
            rank_reg     <= '0;
            cur_reg      <= '0;
            pidx_reg     <= '0;
            col_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            m_reg        <= m_next;
            rank_reg     <= rank_next;
            cur_reg      <= cur_next;
            pidx_reg     <= pidx_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_reg  <= piv_next;
        rrow_reg <= rrow_next;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_EGET)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EGET)
        begin
            out_row_reg  <= ROW_BITS_W'(rd_mat);
            out_op_reg   <= rd_op;
            out_num_reg  <= ROWNUM_W'(cur_reg);
            out_rank_reg <= RANK_W'(rank_reg);
            out_last_reg <= (cur_inc == m_reg);
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.reduced_row   = out_row_reg;
    assign out_ch.operation_row = out_op_reg;
    assign out_ch.row_number    = out_num_reg;
    assign out_ch.rank_value    = out_rank_reg;
    assign out_ch.last_result   = out_last_reg;

    // output slot must be free when a row read returns
    a_eget_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EGET) |-> !out_valid_reg)
        else $error("output word overwritten");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(load_cnt_reg) < MAX_ROWS)
        else $error("load count out of range");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> (rank_reg <= m_reg))
        else $error("rank above row count");

    a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SRCH) || (state_reg == S_PASS) || (state_reg == S_EGET))
        |-> (cur_reg < m_reg))
        else $error("row index past loaded rows");

    a_done_to_col: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.last_row) |=> (state_reg == S_COL))
        else $error("last row did not start elimination");

endmodule
`default_nettype wire
